// ===== hdl/kit_pkg.sv =====
// ----------------------------------------------------------------------------
// kit_pkg: shared types and constants of the keyed item table
// Entry layout, request and status codes, cell control word and sizes.
// ----------------------------------------------------------------------------
package kit_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_CHEAPEST = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_INSTOCK  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        qty;
    logic [31:0]        price;
  } entry_t;

  typedef struct packed {
    logic             rotate;
    logic             load;
    logic             compact;
    logic [CNT_W-1:0] idx;
  } cell_ctl_t;

endpackage

// ===== hdl/kit_if.sv =====
// ----------------------------------------------------------------------------
// kit_if: request and response channels of the keyed item table
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface kit_req_if;
  import kit_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] item_key;
  logic [15:0]        item_quantity;
  logic [31:0]        item_price;

  modport source (output valid, command, item_key, item_quantity, item_price, input ready);
  modport sink   (input valid, command, item_key, item_quantity, item_price, output ready);
endinterface

interface kit_rsp_if;
  import kit_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] found_key;
  logic [15:0]        found_quantity;
  logic [31:0]        found_price;
  logic [6:0]         entry_count;

  modport source (output valid, status, found_key, found_quantity, found_price,
                  entry_count, input ready);
  modport sink   (input valid, status, found_key, found_quantity, found_price,
                  entry_count, output ready);
endinterface

// ===== hdl/keyed_item_table.sv =====
// ----------------------------------------------------------------------------
// keyed_item_table: table of keyed entries with lookup and cheapest search
// Entries sit in a ring of cells in insertion order; each request rotates the
// ring once past a single compare point.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request transaction (command, key, quantity, price); rsp
//   returns exactly one response transaction per request (status, entry found,
//   entry count after the request), in request order.
//   A request is taken only while the block is idle. It then rotates the cell
//   ring once past the head compare, one entry a cycle, and in a finishing
//   step applies an insert or remove and registers the response. The block
//   takes no new request until the current one has left the finishing step.
//   The response register holds its transaction while rsp.ready is low; the
//   next request may still be taken and scanned, and its result waits in the
//   finishing step until the register is free.
//   Reset empties the table at once; entry contents need no clearing.
// ----------------------------------------------------------------------------
module keyed_item_table (
  input logic       clk,
  input logic       rst,
  kit_req_if.sink   req,
  kit_rsp_if.source rsp
);
  import kit_pkg::*;

  entry_t    cells [CAPACITY];
  entry_t    fresh;
  cell_ctl_t ctl;

  kit_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .head  (cells[0]),
    .fresh (fresh),
    .ctl   (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kit_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(i)),
      .right (cells[(i + 1) % CAPACITY]),
      .fresh (fresh),
      .q     (cells[i])
    );
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ctl.rotate && !ctl.load && !ctl.compact)
    else $error("cell ring moved while idle");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.rotate, ctl.load, ctl.compact}))
    else $error("conflicting cell operations");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (int'(rsp.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

  a_rsp_after_scan: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !$past(rsp.valid) && !$past(rst)) |-> $past(ctl.load || ctl.compact ||
      !req.ready))
    else $error("response without a finished request");

endmodule

// ===== hdl/kit_cell.sv =====
// ----------------------------------------------------------------------------
// kit_cell: one table slot in the rotating chain
// Takes its right neighbour on a shift, or the new entry when selected.
// ----------------------------------------------------------------------------
module kit_cell (
  input  logic               clk,
  input  kit_pkg::cell_ctl_t ctl,
  input  logic [kit_pkg::IDX_W-1:0] idx,
  input  kit_pkg::entry_t    right,
  input  kit_pkg::entry_t    fresh,
  output kit_pkg::entry_t    q
);
  import kit_pkg::*;

  logic load_hit;
  logic shift;

  assign load_hit = ctl.load && (CNT_W'(idx) == ctl.idx);
  assign shift    = ctl.rotate || (ctl.compact && (CNT_W'(idx) >= ctl.idx));

  always_ff @(posedge clk) begin
    if (load_hit) begin
      q <= fresh;
    end else if (shift) begin
      q <= right;
    end
  end

endmodule

// ===== hdl/kit_ctrl.sv =====
// ----------------------------------------------------------------------------
// kit_ctrl: sequencer of the keyed item table
// Scans the head of the chain over one full rotation, then applies the change
// and registers the response.
// ----------------------------------------------------------------------------
module kit_ctrl (
  input  logic               clk,
  input  logic               rst,
  kit_req_if.sink            req,
  kit_rsp_if.source          rsp,
  input  kit_pkg::entry_t    head,
  output kit_pkg::entry_t    fresh,
  output kit_pkg::cell_ctl_t ctl
);
  import kit_pkg::*;

  state_t             state, state_next;
  logic [IDX_W-1:0]   step;
  logic [CNT_W-1:0]   fill, fill_next;
  cmd_t               cmd;
  logic signed [31:0] key;
  logic [15:0]        qty;
  logic [31:0]        price;
  logic               hit;
  logic [IDX_W-1:0]   pos;
  entry_t             cap;

  logic               rsp_valid;
  status_t            res_status;
  entry_t             res_entry;
  logic [6:0]         res_count;

  logic               active;
  logic               take;
  logic               fire;
  status_t            st;
  logic               give;
  logic [CNT_W+6:0]   cnt_wide;

  assign fresh  = '{key: key, qty: qty, price: price};
  assign active = CNT_W'(step) < fill;
  assign take   = active && ((cmd == CMD_CHEAPEST) ?
                  ((step == '0) || (head.price < cap.price)) :
                  (!hit && (head.key == key)));
  assign fire   = !rsp_valid || rsp.ready;

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = res_status;
  assign rsp.found_key      = res_entry.key;
  assign rsp.found_quantity = res_entry.qty;
  assign rsp.found_price    = res_entry.price;
  assign rsp.entry_count    = res_count;
  assign cnt_wide           = {7'd0, fill_next};

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    ctl         = '0;
    st          = ST_OK;
    give        = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (fill == CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else if (hit) begin
          st = ST_DUP;
        end
      end
      CMD_REMOVE: begin
        if (fill == '0) begin
          st = ST_EMPTY;
        end else if (!hit) begin
          st = ST_NOTFOUND;
        end else if (cap.qty != '0) begin
          st = ST_INSTOCK;
        end
      end
      CMD_LOOKUP: begin
        if (!hit) begin
          st = ST_NOTFOUND;
        end else begin
          give = 1'b1;
        end
      end
      default: begin
        if (fill == '0) begin
          st = ST_EMPTY;
        end else begin
          give = 1'b1;
        end
      end
    endcase
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.rotate = 1'b1;
        if (step == IDX_W'(CAPACITY - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fire) begin
          state_next = S_IDLE;
          if (st == ST_OK && cmd == CMD_INSERT) begin
            ctl.load  = 1'b1;
            ctl.idx   = fill;
            fill_next = fill + 1'b1;
          end else if (st == ST_OK && cmd == CMD_REMOVE) begin
            ctl.compact = 1'b1;
            ctl.idx     = CNT_W'(pos);
            fill_next   = fill - 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (state == S_FINISH && fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd   <= cmd_t'(req.command);
      key   <= req.item_key;
      qty   <= req.item_quantity;
      price <= req.item_price;
      hit   <= 1'b0;
      step  <= '0;
    end else if (state == S_SCAN) begin
      step <= step + 1'b1;
      if (take) begin
        hit <= 1'b1;
        pos <= step;
        cap <= head;
      end
    end
    if (state == S_FINISH && fire) begin
      res_status <= st;
      res_entry  <= give ? cap : '0;
      res_count  <= cnt_wide[6:0];
    end
  end

endmodule

// ===== test/kit_response_checker.sv =====
// ----------------------------------------------------------------------------
// kit_response_checker: response checker for the keyed item table
// Watches the request and response channels and keeps its own copy of the
// table: every accepted request is applied to that copy and the response it
// should give is queued. Every accepted response is compared field by field
// with the oldest queued one. Failures, outstanding responses and a few
// figures on the table's use are handed to the testbench top.
// ----------------------------------------------------------------------------
module kit_response_checker (
  input  logic clk,
  input  logic rst,
  kit_req_if   req,
  kit_rsp_if   rsp,
  output int   fails,
  output int   open_count,
  output int   replies_seen,
  output int   full_rejects,
  output int   peak_fill
);
  import kit_pkg::*;

  typedef struct packed {
    status_t    status;
    entry_t     hit;
    logic [6:0] count;
  } reply_t;

  entry_t shelf [CAPACITY];
  int     shelf_fill;
  reply_t replies_due [$];
  int     mismatch_total;
  int     reply_total;
  int     full_total;
  int     fill_high;

  function automatic reply_t apply_request(input cmd_t op, input entry_t arg);
    reply_t r;
    int     pos;
    int     i;
    r        = '0;
    r.status = ST_OK;
    pos      = -1;
    if (op != CMD_CHEAPEST) begin
      for (i = 0; i < shelf_fill; i++)
        if (pos < 0 && shelf[i].key == arg.key) pos = i;
    end
    case (op)
      CMD_INSERT: begin
        if (shelf_fill >= CAPACITY) begin
          r.status = ST_FULL;
          full_total++;
        end else if (pos >= 0) begin
          r.status = ST_DUP;
        end else begin
          shelf[shelf_fill] = arg;
          shelf_fill++;
        end
      end
      CMD_REMOVE: begin
        if (shelf_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else if (shelf[pos].qty != '0) begin
          r.status = ST_INSTOCK;
        end else begin
          for (i = pos + 1; i < shelf_fill; i++) shelf[i-1] = shelf[i];
          shelf_fill--;
        end
      end
      CMD_LOOKUP: begin
        if (pos < 0) r.status = ST_NOTFOUND;
        else r.hit = shelf[pos];
      end
      default: begin
        if (shelf_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          for (i = 1; i < shelf_fill; i++)
            if (shelf[i].price < shelf[pos].price) pos = i;
          r.hit = shelf[pos];
        end
      end
    endcase
    r.count = 7'(shelf_fill);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    entry_t arg;
    if (rst) begin
      shelf_fill     = 0;
      mismatch_total = 0;
      reply_total    = 0;
      full_total     = 0;
      fill_high      = 0;
      replies_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        reply_total++;
        if (replies_due.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                   $time, rsp.status, rsp.entry_count);
        end else begin
          want = replies_due.pop_front();
          compare_field("status", want.status, rsp.status);
          compare_field("found_key", want.hit.key, rsp.found_key);
          compare_field("found_quantity", want.hit.qty, rsp.found_quantity);
          compare_field("found_price", want.hit.price, rsp.found_price);
          compare_field("entry_count", want.count, rsp.entry_count);
        end
      end
      if (req.valid && req.ready) begin
        arg.key   = req.item_key;
        arg.qty   = req.item_quantity;
        arg.price = req.item_price;
        replies_due.push_back(apply_request(cmd_t'(req.command), arg));
        if (shelf_fill > fill_high) fill_high = shelf_fill;
      end
    end
    fails        <= mismatch_total;
    open_count   <= replies_due.size();
    replies_seen <= reply_total;
    full_rejects <= full_total;
    peak_fill    <= fill_high;
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the keyed item table
// Drives requests in bursts with random gaps and stalls the response channel
// on its own random pattern. A short directed sequence covers the empty,
// duplicate, missing key, in-stock and tied-price cases; random fill and
// drain phases then push the table to full and back. A response checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import kit_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int PLAIN_KEYS   = 72;
  localparam int STOCK_KEYS   = 6;
  localparam int STALL_LIMIT  = 3000;

  logic        clk;
  logic        rst;
  int          fails;
  int          open_count;
  int          replies_seen;
  int          full_rejects;
  int          peak_fill;
  int          items_sent;
  int          burst_left;
  int          idle_cycles = 0;
  int          phase_left;
  int          roll;
  int          rx_roll;
  int          ready_pct;
  int          ready_span;
  bit          filling;
  logic [31:0] plain_keys [PLAIN_KEYS];
  logic [31:0] stock_keys [STOCK_KEYS];
  logic [31:0] pick_key;
  logic [15:0] pick_qty;
  logic [31:0] pick_price;

  kit_req_if req_ch ();
  kit_rsp_if rsp_ch ();

  keyed_item_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kit_response_checker replies_chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fails        (fails),
    .open_count   (open_count),
    .replies_seen (replies_seen),
    .full_rejects (full_rejects),
    .peak_fill    (peak_fill)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic offer(input cmd_t op, input logic [31:0] key, input logic [15:0] qty,
                       input logic [31:0] price);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.command       <= op;
    req_ch.item_key      <= key;
    req_ch.item_quantity <= qty;
    req_ch.item_price    <= price;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.command       <= CMD_INSERT;
    req_ch.item_key      <= '0;
    req_ch.item_quantity <= '0;
    req_ch.item_price    <= '0;
    items_sent = 0;
    burst_left = 0;
    phase_left = 0;
    filling    = 1'b0;
    for (int i = 0; i < PLAIN_KEYS; i++) plain_keys[i] = $urandom;
    for (int i = 0; i < STOCK_KEYS; i++) stock_keys[i] = $urandom;
    plain_keys[0] = 32'h8000_0000;
    plain_keys[1] = 32'hFFFF_FFFF;
    stock_keys[0] = 32'h7FFF_FFFF;
    stock_keys[1] = 32'h0000_0000;

    fork
      forever begin
        rx_roll    = $urandom_range(0, 3);
        ready_pct  = (rx_roll == 0) ? 0 : (rx_roll == 1) ? 30 : (rx_roll == 2) ? 70 : 100;
        ready_span = (ready_pct == 0) ? $urandom_range(1, 120) : $urandom_range(10, 300);
        repeat (ready_span) begin
          rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
          @(posedge clk);
        end
      end
    join_none

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, then ties, duplicates, missing keys and stock held
    offer(CMD_CHEAPEST, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    offer(CMD_REMOVE,   32'h8000_0000, 16'h0000, 32'h0000_0000);
    offer(CMD_LOOKUP,   32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF);
    offer(CMD_INSERT,   32'h8000_0000, 16'h0000, 32'hFFFF_FFFF);
    offer(CMD_INSERT,   32'h7FFF_FFFF, 16'hFFFF, 32'h0000_0000);
    offer(CMD_INSERT,   32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(CMD_INSERT,   32'h0000_0000, 16'h0001, 32'h0000_0005);
    offer(CMD_INSERT,   32'h8000_0000, 16'hFFFF, 32'h0000_0007);
    offer(CMD_LOOKUP,   32'h7FFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(CMD_LOOKUP,   32'h1234_5678, 16'h0000, 32'h0000_0000);
    offer(CMD_CHEAPEST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer(CMD_REMOVE,   32'h7FFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(CMD_REMOVE,   32'h1234_5678, 16'h0000, 32'h0000_0000);
    offer(CMD_REMOVE,   32'h8000_0000, 16'h0000, 32'h0000_0000);
    offer(CMD_LOOKUP,   32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(CMD_REMOVE,   32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    offer(CMD_CHEAPEST, 32'h0000_0000, 16'h0000, 32'h0000_0000);

    // alternate fill and drain phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = filling ? $urandom_range(80, 200) : $urandom_range(50, 130);
      end
      phase_left--;
      roll       = $urandom_range(0, 99);
      pick_key   = (roll < 70) ? plain_keys[$urandom_range(0, PLAIN_KEYS - 1)] :
                   (roll < 85) ? stock_keys[$urandom_range(0, STOCK_KEYS - 1)] : $urandom;
      pick_qty   = $urandom;
      pick_price = $urandom;
      roll       = $urandom_range(0, 99);
      if (roll < (filling ? 85 : 15)) begin
        if ($urandom_range(0, 19) == 0) begin
          pick_key = stock_keys[$urandom_range(0, STOCK_KEYS - 1)];
          pick_qty = $urandom_range(1, 65535);
        end else begin
          pick_key = plain_keys[$urandom_range(0, PLAIN_KEYS - 1)];
          pick_qty = '0;
        end
        roll = $urandom_range(0, 9);
        if (roll < 3) pick_price = (roll == 0) ? 32'h0 : (roll == 1) ? 32'd500 : 32'hFFFF_FFFF;
        else if (roll == 3) pick_price = $urandom_range(0, 3);
        offer(CMD_INSERT, pick_key, pick_qty, pick_price);
      end else if (roll < (filling ? 90 : 75)) begin
        offer(CMD_REMOVE, pick_key, pick_qty, pick_price);
      end else if (roll < (filling ? 95 : 91)) begin
        offer(CMD_LOOKUP, pick_key, pick_qty, pick_price);
      end else begin
        offer(CMD_CHEAPEST, pick_key, pick_qty, pick_price);
      end
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (3 * CAPACITY) @(posedge clk);

    $display("Sent %0d requests, checked %0d responses; table peaked at %0d of %0d entries",
             items_sent, replies_seen, peak_fill, CAPACITY);
    $display("with %0d inserts refused on a full table.", full_rejects);
    if (fails == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
